// ===== hw/rtl/functional_graph_kth_successor_unit_macros.svh =====
// assertion macros for the kth successor unit
// expects clk and rst_n in the scope of each use
`ifndef FUNCTIONAL_GRAPH_KTH_SUCCESSOR_UNIT_MACROS_SVH
`define FUNCTIONAL_GRAPH_KTH_SUCCESSOR_UNIT_MACROS_SVH

// checked only outside reset
`define FGKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FGKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fgks_pkg.sv =====
// shared types and constants of the kth successor unit
// no dependencies
package fgks_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 62;
  localparam int JUMP_W        = 62;
  localparam int SUCC_W        = 11;

  typedef struct packed {
    logic [SUCC_W-1:0] successor;
    logic              last_entry;
  } in_t;

  typedef struct packed {
    logic [SUCC_W-1:0] final_node;
    logic              table_error;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD_A,
    S_BUILD_B,
    S_BUILD_W,
    S_WALK_A,
    S_WALK_B
  } state_t;

endpackage

// ===== hw/rtl/fgks_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module fgks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/functional_graph_kth_successor_unit.sv =====
// kth successor of node 1 in a functional graph, by binary lifting
// depends on fgks_pkg, fgks_ram and functional_graph_kth_successor_unit_macros.svh
//
// A user loads a successor table one entry per transaction (start high while
// busy is low), one entry per cycle; entry i names the one-based node that
// node i points to. The entry with last_entry set closes the table (N entries)
// and launches the search from node 1 over cfg jump_count steps. A table with
// a successor of 0 or above N, or with more than MAX_NODES entries, returns at
// once, in the cycle after the last entry, with table_error set and
// final_node 0; no search runs then. Otherwise busy rises and the unit builds
// the doubling levels in one single-port-read memory: each level visits every
// entry (read the entry, read the entry it points to, write the next level),
// then the walk reads one level per jump bit up to min(LEVELS,62). The result
// appears on out_data for exactly one cycle with out_valid high; the receiver
// cannot stall it, so it must take it then. busy falls in the cycle the result
// is shown, and the next table may load right away. The user must write
// jump_count through cfg_we/cfg_wdata only while the unit is idle; the unit
// does not enforce this. Bits at LEVELS and above are ignored. No clearing pass
// follows reset: the table memory is only read where it was written.
module functional_graph_kth_successor_unit #(
  parameter int MAX_NODES = fgks_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = fgks_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  fgks_pkg::in_t               in_data,
  // result channel
  output logic                        out_valid,
  output fgks_pkg::out_t              out_data,
  // configuration
  input  logic                        cfg_we,
  input  logic [fgks_pkg::JUMP_W-1:0] cfg_wdata
);

  localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int RAM_DEPTH = LEVELS * (1 << NODE_W);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int WALK_N    = (LEVELS < fgks_pkg::JUMP_W) ? LEVELS : fgks_pkg::JUMP_W;
  localparam int SW        = fgks_pkg::SUCC_W;

  // control state
  fgks_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;      // entries of the table being loaded
  logic [SW-1:0]     max_r;      // largest stored successor so far
  logic              bad_r;      // bad successor or overflow so far
  logic [CNT_W-1:0]  n_r;        // table size for the current search
  logic [LVL_W-1:0]  lvl_r;      // doubling level being built or walked
  logic [NODE_W-1:0] idx_r;      // entry within a level during the build
  logic [NODE_W-1:0] node_r;     // zero-based node during the walk
  logic [fgks_pkg::JUMP_W-1:0] jump_count_r;
  logic              out_valid_r;
  fgks_pkg::out_t    out_data_r;

  // memory port
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [NODE_W-1:0] ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [NODE_W-1:0] ram_rdata;

  // load path
  logic              accept;
  logic              succ_bad;
  logic              room;
  logic [CNT_W-1:0]  cnt_inc;
  logic [SW-1:0]     max_inc;
  logic              table_bad;
  logic              idx_last;
  logic              lvl_top;
  logic              walk_last;

  fgks_ram #(
    .WIDTH (NODE_W),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept = start && !busy;

  // entry checks as it arrives; a dropped entry is flagged through room
  always_comb begin
    succ_bad  = (in_data.successor == '0) || (32'(in_data.successor) > 32'(MAX_NODES));
    room      = (32'(cnt_r) < 32'(MAX_NODES));
    cnt_inc   = room ? (cnt_r + CNT_W'(1)) : cnt_r;
    max_inc   = (room && (in_data.successor > max_r)) ? in_data.successor : max_r;
    // any stored successor past the final count breaks the table
    table_bad = bad_r || succ_bad || !room || (32'(max_inc) > 32'(cnt_inc));
  end

  assign idx_last  = (CNT_W'(idx_r) == (n_r - CNT_W'(1)));
  assign lvl_top   = (lvl_r == LVL_W'(LEVELS - 2));
  assign walk_last = (lvl_r == LVL_W'(WALK_N - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fgks_pkg::S_IDLE: begin
        if (accept && in_data.last_entry && !table_bad) begin
          state_nxt = (LEVELS > 1) ? fgks_pkg::S_BUILD_A : fgks_pkg::S_WALK_A;
        end
      end
      fgks_pkg::S_BUILD_A: state_nxt = fgks_pkg::S_BUILD_B;
      fgks_pkg::S_BUILD_B: state_nxt = fgks_pkg::S_BUILD_W;
      fgks_pkg::S_BUILD_W: begin
        state_nxt = (idx_last && lvl_top) ? fgks_pkg::S_WALK_A : fgks_pkg::S_BUILD_A;
      end
      fgks_pkg::S_WALK_A:  state_nxt = fgks_pkg::S_WALK_B;
      fgks_pkg::S_WALK_B: begin
        state_nxt = walk_last ? fgks_pkg::S_IDLE : fgks_pkg::S_WALK_A;
      end
      default:   state_nxt = fgks_pkg::S_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  // the build writes level d+1 while it reads level d only; the first read of
  // a new level comes in the cycle after the last write, so no forwarding is needed
  always_comb begin
    busy      = (state_r != fgks_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = RAM_AW'({LVL_W'(0), NODE_W'(cnt_r)});
    ram_wdata = succ_bad ? '0 : NODE_W'(in_data.successor - SW'(1));
    ram_raddr = RAM_AW'({lvl_r, idx_r});
    case (state_r)
      fgks_pkg::S_IDLE: begin
        ram_we = accept && room;
      end
      fgks_pkg::S_BUILD_A: ram_raddr = RAM_AW'({lvl_r, idx_r});
      fgks_pkg::S_BUILD_B: ram_raddr = RAM_AW'({lvl_r, ram_rdata});   // hop through the mid node
      fgks_pkg::S_BUILD_W: begin
        ram_we    = 1'b1;
        ram_waddr = RAM_AW'({lvl_r + LVL_W'(1), idx_r});
        ram_wdata = ram_rdata;
      end
      fgks_pkg::S_WALK_A:  ram_raddr = RAM_AW'({lvl_r, node_r});
      fgks_pkg::S_WALK_B:  ram_raddr = RAM_AW'({lvl_r, node_r});
      default:   ram_raddr = RAM_AW'({lvl_r, idx_r});
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fgks_pkg::S_IDLE;
      cnt_r        <= '0;
      max_r        <= '0;
      bad_r        <= 1'b0;
      jump_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        jump_count_r <= cfg_wdata;
      end
      case (state_r)
        fgks_pkg::S_IDLE: begin
          if (accept) begin
            if (in_data.last_entry) begin
              // table closes; start the next one from empty
              cnt_r  <= '0;
              max_r  <= '0;
              bad_r  <= 1'b0;
              n_r    <= cnt_inc;
              lvl_r  <= '0;
              idx_r  <= '0;
              node_r <= '0;
              if (table_bad) begin
                out_valid_r            <= 1'b1;
                out_data_r.final_node  <= '0;
                out_data_r.table_error <= 1'b1;
              end
            end else begin
              // the range check against the count waits for the last entry
              cnt_r <= cnt_inc;
              max_r <= max_inc;
              bad_r <= bad_r || succ_bad || !room;
            end
          end
        end
        fgks_pkg::S_BUILD_W: begin
          if (idx_last) begin
            idx_r <= '0;
            lvl_r <= lvl_top ? '0 : (lvl_r + LVL_W'(1));
          end else begin
            idx_r <= idx_r + NODE_W'(1);
          end
        end
        fgks_pkg::S_WALK_B: begin
          if (jump_count_r[lvl_r]) begin
            node_r <= ram_rdata;
          end
          if (walk_last) begin
            out_valid_r            <= 1'b1;
            out_data_r.final_node  <= SW'(jump_count_r[lvl_r] ? ram_rdata : node_r) + SW'(1);
            out_data_r.table_error <= 1'b0;
          end else begin
            lvl_r <= lvl_r + LVL_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "functional_graph_kth_successor_unit_macros.svh"

  // a clean result only ever leaves the end of the walk
  `FGKS_ASSERT(a_clean_from_walk,
    (out_valid && !out_data.table_error) |-> ($past(state_r) == fgks_pkg::S_WALK_B),
    "clean result without a walk")
  // the build never steps past the loaded table
  `FGKS_ASSERT(a_build_in_table,
    (state_r == fgks_pkg::S_BUILD_A) |-> (CNT_W'(idx_r) < n_r),
    "build index beyond table")
  // the walk only visits loaded nodes
  `FGKS_ASSERT(a_walk_in_table,
    (state_r == fgks_pkg::S_WALK_A) |-> (CNT_W'(node_r) < n_r),
    "walk node beyond table")
  // reset kills any pending strobe
  `FGKS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

// ===== verif/functional_graph_kth_successor_unit_test.sv =====
// self-checking testbench for functional_graph_kth_successor_unit
// depends on fgks_pkg and the unit's rtl, nothing else
`timescale 1ns / 100ps

module functional_graph_kth_successor_unit_test;

  localparam int NODES        = fgks_pkg::MAX_NODES_DEF;
  localparam int LIFT_LEVELS  = fgks_pkg::LEVELS_DEF;
  localparam int WIDE_MAX     = 2**fgks_pkg::SUCC_W - 1;
  // the slowest legal stretch without any transaction is one full build and
  // walk of the largest random table, 40 entries; allow ~7x that
  localparam int STALL_LIMIT  = 50_000;
  localparam int DRAIN_CYCLES = 256;
  localparam int PHASE_ITEMS  = 100;
  localparam int RAND_PHASES  = 8;
  localparam logic [fgks_pkg::JUMP_W-1:0] JUMP_ALL = '1;

  // flavors of table that the stimulus builds
  typedef enum {
    TBL_VALID,     // every successor in 1..N
    TBL_ZERO,      // one successor of zero
    TBL_PAST_END,  // one successor above N but within MAX_NODES
    TBL_WIDE,      // one successor above MAX_NODES
    TBL_NOISE      // every successor random over the whole field
  } table_kind_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start   = 1'b0;
  logic                          busy;
  fgks_pkg::in_t                 in_data = '0;
  logic                          out_valid;
  fgks_pkg::out_t                out_data;
  logic                          cfg_we;
  logic [fgks_pkg::JUMP_W-1:0]   cfg_wdata;

  functional_graph_kth_successor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the lifting table and the jump register
  // ---------------------------------------------------------------------------
  logic [9:0]                    hop_table [LIFT_LEVELS][NODES];
  int unsigned                   loaded_cnt;
  bit                            malformed_seen;
  logic [fgks_pkg::JUMP_W-1:0]   jump_steps;
  fgks_pkg::out_t                expected_nodes[$];

  // stimulus bookkeeping
  fgks_pkg::in_t       pending_entries[$];
  int                  entries_in_flight;
  int                  idle_pct;
  bit                  entry_taken;
  int                  stall_cycles;
  int                  mismatch_cnt;
  int                  entries_sent;
  int                  results_seen;
  int                  error_results;
  int                  jump_settings;

  // fold one accepted table entry into the predictor; a closing entry
  // produces the expected result and starts a fresh table
  task automatic absorb_entry(fgks_pkg::in_t e);
    int unsigned    n;
    logic [9:0]     node;
    fgks_pkg::out_t res;
    if (loaded_cnt < NODES) begin
      if (e.successor == 0 || e.successor > NODES) begin
        malformed_seen = 1'b1;
        hop_table[0][loaded_cnt] = '0;
      end else begin
        hop_table[0][loaded_cnt] = 10'(e.successor - 1);
      end
      loaded_cnt++;
    end else begin
      // overflow: entry dropped, table flagged
      malformed_seen = 1'b1;
    end
    if (!e.last_entry) return;

    n = loaded_cnt;
    for (int j = 0; j < n; j++)
      if (hop_table[0][j] >= n) malformed_seen = 1'b1;

    if (malformed_seen) begin
      res.final_node  = '0;
      res.table_error = 1'b1;
    end else begin
      // level d+1 is level d taken twice
      for (int d = 0; d + 1 < LIFT_LEVELS; d++)
        for (int j = 0; j < n; j++)
          hop_table[d+1][j] = hop_table[d][hop_table[d][j]];
      node = '0;
      for (int d = 0; d < LIFT_LEVELS && d < fgks_pkg::JUMP_W; d++)
        if (jump_steps[d]) node = hop_table[d][node];
      res.final_node  = fgks_pkg::SUCC_W'(node) + 1'b1;
      res.table_error = 1'b0;
    end
    expected_nodes = {expected_nodes, res};
    loaded_cnt     = 0;
    malformed_seen = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued entries on the falling edge, holds each one until
  // the unit takes it, and idles at random
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || entry_taken) begin
      if (pending_entries.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        in_data <= pending_entries.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels at the rising edge, feeds the predictor
  // and checks each result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fgks_pkg::out_t want;
    entry_taken = rst_n && start && !busy;
    if (entry_taken) begin
      entries_in_flight--;
      entries_sent++;
      absorb_entry(in_data);
    end
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_data.table_error) error_results++;
      if (expected_nodes.size() == 0) begin
        $error("result transaction with nothing expected: final_node=%0d table_error=%0b",
               out_data.final_node, out_data.table_error);
        mismatch_cnt++;
      end else begin
        want = expected_nodes.pop_front();
        if (out_data.final_node !== want.final_node) begin
          $error("final_node: expected %0d, actual %0d", want.final_node,
                 out_data.final_node);
          mismatch_cnt++;
        end
        if (out_data.table_error !== want.table_error) begin
          $error("table_error: expected %0b, actual %0b", want.table_error,
                 out_data.table_error);
          mismatch_cnt++;
        end
      end
    end
    // any transaction on either side resets the hang detector
    if (entry_taken || (rst_n && out_valid)) stall_cycles = 0;
    else stall_cycles++;
  end

  // hang detector
  initial begin : watchdog
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("timeout: no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, expected_nodes.size());
    $display("** functional_graph_kth_successor_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_entry(int s, bit last);
    fgks_pkg::in_t e;
    e.successor  = fgks_pkg::SUCC_W'(s);
    e.last_entry = last;
    pending_entries = {pending_entries, e};
    entries_in_flight++;
  endtask

  // returns once every queued entry is taken and every result is back;
  // all tables are closed by then, so the unit is idle
  task automatic wait_idle();
    do @(negedge clk); while (entries_in_flight != 0 || expected_nodes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // jump register write, only from idle
  task automatic set_jump(logic [fgks_pkg::JUMP_W-1:0] v);
    wait_idle();
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    jump_steps  = v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    @(posedge clk);
    jump_settings++;
  endtask

  task automatic queue_table(int n, table_kind_t kind);
    int top;
    int bad_at;
    int s;
    top    = (n < NODES) ? n : NODES;
    bad_at = $urandom_range(n - 1, 0);
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(top, 1);
      if (i == bad_at) begin
        case (kind)
          TBL_ZERO:     s = 0;
          TBL_PAST_END: s = $urandom_range(NODES, n + 1);
          TBL_WIDE:     s = $urandom_range(WIDE_MAX, NODES + 1);
          // a full valid table always points somewhere at the top node
          TBL_VALID:    if (n >= NODES) s = NODES;
          default:      ;
        endcase
      end
      if (kind == TBL_NOISE) s = $urandom_range(WIDE_MAX, 0);
      push_entry(s, i == n - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0]                 rnd;
    logic [fgks_pkg::JUMP_W-1:0] jump;
    int                          phase_items;
    int                          n;
    int                          pick;
    table_kind_t                 kind;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    idle_pct          = 31;
    loaded_cnt        = 0;
    malformed_seen    = 1'b0;
    jump_steps        = '0;
    entries_in_flight = 0;
    stall_cycles      = 0;
    mismatch_cnt      = 0;
    entries_sent      = 0;
    results_seen      = 0;
    error_results     = 0;
    jump_settings     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero steps, single self loop and a small cycle
    set_jump('0);
    push_entry(1, 1);
    push_entry(2, 0); push_entry(3, 0); push_entry(1, 1);

    // directed: every jump bit set, two valid tables and malformed ones with zero, past-N and wide successors
    set_jump(JUMP_ALL);
    push_entry(2, 0); push_entry(3, 0); push_entry(1, 1);
    push_entry(2, 0); push_entry(3, 0); push_entry(4, 0); push_entry(4, 1);
    push_entry(0, 1);                                  // zero successor
    push_entry(2, 0); push_entry(3, 1);                // successor past N
    push_entry(WIDE_MAX, 1);                           // all field bits set
    push_entry(1, 0); push_entry(NODES, 0); push_entry(1, 1);

    // directed: only the top jump bit
    set_jump(fgks_pkg::JUMP_W'(1) << (fgks_pkg::JUMP_W - 1));
    push_entry(2, 0); push_entry(3, 0); push_entry(4, 0); push_entry(5, 0);
    push_entry(1, 1);
    push_entry(2, 0); push_entry(1, 1);

    // random phases, each with its own jump setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      rnd = {$urandom(), $urandom()};
      case (p)
        1:       jump = JUMP_ALL;
        2:       jump = fgks_pkg::JUMP_W'(1) << $urandom_range(fgks_pkg::JUMP_W - 1, 0);
        3:       jump = '0;
        5:       jump = fgks_pkg::JUMP_W'($urandom_range(15, 1));
        default: jump = rnd[fgks_pkg::JUMP_W-1:0];
      endcase
      set_jump(jump);
      // one phase runs with the driver never idling
      idle_pct = (p == 2) ? 0 : 31;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        pick = $urandom_range(99);
        if (pick < 70)      kind = TBL_VALID;
        else if (pick < 78) kind = TBL_ZERO;
        else if (pick < 86) kind = TBL_PAST_END;
        else if (pick < 93) kind = TBL_WIDE;
        else                kind = TBL_NOISE;
        queue_table(n, kind);
        phase_items += n;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d table entries over %0d jump settings", entries_sent,
             jump_settings);
    $display("%0d results checked, %0d of them flagged malformed tables", results_seen,
             error_results);
    if (mismatch_cnt == 0) begin
      $display("** functional_graph_kth_successor_unit: PASSED **");
    end else begin
      $display("** functional_graph_kth_successor_unit: FAILED **");
    end
    $finish;
  end

endmodule
